/* rtl/hpt_pkg.sv */
// ============================================================================
// Homogeneous point transform package
// Shared widths, register indexes, reset values and pipeline types.
// ============================================================================
package hpt_pkg;

    localparam int COORD_W = 32;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 4;
    localparam int NUM_REGS = 8;
    localparam int PROD_W  = 64;
    localparam int SUM_W   = 66;
    localparam int ROW_W   = 51;
    localparam int QUO_W   = 32;
    localparam int FRAC_W  = 16;

    localparam logic [IDX_W-1:0] REG_X_AB = 4'd0;
    localparam logic [IDX_W-1:0] REG_X_CD = 4'd1;
    localparam logic [IDX_W-1:0] REG_Y_AB = 4'd2;
    localparam logic [IDX_W-1:0] REG_Y_CD = 4'd3;
    localparam logic [IDX_W-1:0] REG_Z_AB = 4'd4;
    localparam logic [IDX_W-1:0] REG_Z_CD = 4'd5;
    localparam logic [IDX_W-1:0] REG_W_AB = 4'd6;
    localparam logic [IDX_W-1:0] REG_W_CD = 4'd7;

    localparam logic [CFG_W-1:0] RST_X_AB = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] RST_X_CD = 64'h0;
    localparam logic [CFG_W-1:0] RST_Y_AB = 64'h0001_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_Y_CD = 64'h0;
    localparam logic [CFG_W-1:0] RST_Z_AB = 64'h0;
    localparam logic [CFG_W-1:0] RST_Z_CD = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] RST_W_AB = 64'h0;
    localparam logic [CFG_W-1:0] RST_W_CD = 64'h0001_0000_0000_0000;

    localparam logic signed [ROW_W-1:0] Q_ONE = 51'sd65536;
    localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

    // One coordinate lane as it moves through the divider stages.
    typedef struct packed {
        logic signed [ROW_W-1:0] v;
        logic                    neg;
        logic                    ovf;
        logic [ROW_W-1:0]        rem;
        logic [QUO_W-1:0]        dvd_lo;
        logic [QUO_W-1:0]        quo;
    } lane_t;

    typedef struct packed {
        logic             w_one;
        logic             w_zero;
        logic [ROW_W-1:0] ud;
        lane_t [2:0]      lanes;
    } div_item_t;

endpackage

/* rtl/hpt_if.sv */
// ============================================================================
// Homogeneous point transform channels
// Valid/ready channels for input points and transformed results.
// ============================================================================
interface hpt_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [hpt_pkg::COORD_W-1:0] point_x;
    logic signed [hpt_pkg::COORD_W-1:0] point_y;
    logic signed [hpt_pkg::COORD_W-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface hpt_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [hpt_pkg::COORD_W-1:0] result_x;
    logic signed [hpt_pkg::COORD_W-1:0] result_y;
    logic signed [hpt_pkg::COORD_W-1:0] result_z;
    logic                                w_was_zero;
    logic                                saturated;

    modport source (output valid, result_x, result_y, result_z, w_was_zero, saturated,
                    input ready);
    modport sink   (input valid, result_x, result_y, result_z, w_was_zero, saturated,
                    output ready);
endinterface

/* rtl/homogeneous_point_transform_unit.sv */
// ============================================================================
// Homogeneous point transform unit
// 4x4 transform of a Q16.16 point with implied w = 1 and perspective divide.
// ============================================================================
// One point enters per clock and one result leaves per clock when the output
// side is ready. Most of the pipeline depth comes from the restoring divider,
// which resolves one quotient bit per stage over 32 stages for all three lanes
// at once; ahead of it sit an input stage, a multiplier stage (twelve 32x32
// products), a row-sum stage and a setup stage. The whole pipeline advances
// together whenever the output register is empty or being taken, so a stall
// holds every stage. Matrix registers are written through cfg_we/cfg_index/
// cfg_data and must only change while no beat is in flight.
module homogeneous_point_transform_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    hpt_point_if.sink                    pt,
    hpt_result_if.source                 res,
    input  logic                         cfg_we,
    input  logic [hpt_pkg::IDX_W-1:0]    cfg_index,
    input  logic [hpt_pkg::CFG_W-1:0]    cfg_data
);

    localparam int NDIV = hpt_pkg::QUO_W;

    // Matrix registers.
    logic [hpt_pkg::CFG_W-1:0] mat_reg [hpt_pkg::NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= hpt_pkg::RST_X_AB;
            mat_reg[1] <= hpt_pkg::RST_X_CD;
            mat_reg[2] <= hpt_pkg::RST_Y_AB;
            mat_reg[3] <= hpt_pkg::RST_Y_CD;
            mat_reg[4] <= hpt_pkg::RST_Z_AB;
            mat_reg[5] <= hpt_pkg::RST_Z_CD;
            mat_reg[6] <= hpt_pkg::RST_W_AB;
            mat_reg[7] <= hpt_pkg::RST_W_CD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hpt_pkg::REG_X_AB: mat_reg[0] <= cfg_data;
                hpt_pkg::REG_X_CD: mat_reg[1] <= cfg_data;
                hpt_pkg::REG_Y_AB: mat_reg[2] <= cfg_data;
                hpt_pkg::REG_Y_CD: mat_reg[3] <= cfg_data;
                hpt_pkg::REG_Z_AB: mat_reg[4] <= cfg_data;
                hpt_pkg::REG_Z_CD: mat_reg[5] <= cfg_data;
                hpt_pkg::REG_W_AB: mat_reg[6] <= cfg_data;
                hpt_pkg::REG_W_CD: mat_reg[7] <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves when the output register can take a beat.
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || res.ready;
    assign pt.ready = adv;

    // Stage 1: input capture.
    logic                                s1_valid_reg;
    logic signed [hpt_pkg::COORD_W-1:0] s1_pt_reg [3];

    // Stage 2: products, row r and coordinate c.
    logic                                s2_valid_reg;
    logic signed [hpt_pkg::PROD_W-1:0]  s2_prod_reg [4][3];

    // Stage 3: wide row sums (x, y, z, w).
    logic                                s3_valid_reg;
    logic signed [hpt_pkg::ROW_W-1:0]   s3_row_reg [4];

    // Divider stages; index 0 is the setup stage.
    logic                  div_valid_reg [NDIV+1];
    hpt_pkg::div_item_t    div_reg       [NDIV+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pt.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pt_reg[0] <= pt.point_x;
            s1_pt_reg[1] <= pt.point_y;
            s1_pt_reg[2] <= pt.point_z;
        end
    end

    // Coefficient r,c of the matrix: X and Y in the ab register, Z in cd.
    logic signed [hpt_pkg::COORD_W-1:0] coef [4][3];
    logic signed [hpt_pkg::COORD_W-1:0] offs [4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            coef[r][0] = signed'(mat_reg[2*r][31:0]);
            coef[r][1] = signed'(mat_reg[2*r][63:32]);
            coef[r][2] = signed'(mat_reg[2*r+1][31:0]);
            offs[r]    = signed'(mat_reg[2*r+1][63:32]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    s2_prod_reg[r][c] <= hpt_pkg::PROD_W'(s1_pt_reg[c])
                                         * hpt_pkg::PROD_W'(coef[r][c]);
                end
            end
        end
    end

    // Row sum: floor(exact dot / 2^16) plus the row offset, kept wide.
    logic signed [hpt_pkg::SUM_W-1:0] dot [4];
    logic signed [hpt_pkg::ROW_W-1:0] row_next [4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            dot[r] = hpt_pkg::SUM_W'(s2_prod_reg[r][0])
                   + hpt_pkg::SUM_W'(s2_prod_reg[r][1])
                   + hpt_pkg::SUM_W'(s2_prod_reg[r][2]);
            row_next[r] = hpt_pkg::ROW_W'(signed'(dot[r][hpt_pkg::SUM_W-1:hpt_pkg::FRAC_W]))
                        + hpt_pkg::ROW_W'(offs[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
            begin
                s3_row_reg[r] <= row_next[r];
            end
        end
    end

    // Setup: magnitudes, signs, and the quotient overflow test. The divider
    // then forms floor(|v| * 2^16 / |w|), which fits 32 bits when ovf is clear.
    hpt_pkg::div_item_t setup_next;
    logic w_neg;
    logic [hpt_pkg::ROW_W-1:0] un [3];

    always_comb
    begin
        w_neg = s3_row_reg[3] < 0;
        setup_next.w_one  = s3_row_reg[3] == hpt_pkg::Q_ONE;
        setup_next.w_zero = s3_row_reg[3] == '0;
        setup_next.ud     = w_neg ? hpt_pkg::ROW_W'(-s3_row_reg[3])
                                  : hpt_pkg::ROW_W'(s3_row_reg[3]);
        for (int c = 0; c < 3; c++)
        begin
            un[c] = s3_row_reg[c] < 0 ? hpt_pkg::ROW_W'(-s3_row_reg[c])
                                      : hpt_pkg::ROW_W'(s3_row_reg[c]);
            setup_next.lanes[c].v      = s3_row_reg[c];
            setup_next.lanes[c].neg    = (s3_row_reg[c] < 0) != w_neg;
            setup_next.lanes[c].ovf    = {16'h0000, un[c]}
                                         >= {setup_next.ud, 16'h0000};
            setup_next.lanes[c].rem    = hpt_pkg::ROW_W'(un[c][hpt_pkg::ROW_W-1:16]);
            setup_next.lanes[c].dvd_lo = {un[c][15:0], 16'h0000};
            setup_next.lanes[c].quo    = '0;
        end
    end

    // One restoring division step.
    function automatic hpt_pkg::lane_t div_step(hpt_pkg::lane_t l,
                                                logic [hpt_pkg::ROW_W-1:0] ud);
        hpt_pkg::lane_t o;
        logic [hpt_pkg::ROW_W:0] sh;
        logic [hpt_pkg::ROW_W:0] diff;
        o    = l;
        sh   = {l.rem, l.dvd_lo[hpt_pkg::QUO_W-1]};
        diff = sh - {1'b0, ud};
        o.dvd_lo = {l.dvd_lo[hpt_pkg::QUO_W-2:0], 1'b0};
        if (sh >= {1'b0, ud})
        begin
            o.rem = diff[hpt_pkg::ROW_W-1:0];
            o.quo = {l.quo[hpt_pkg::QUO_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = sh[hpt_pkg::ROW_W-1:0];
            o.quo = {l.quo[hpt_pkg::QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NDIV; k++)
            begin
                div_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            div_valid_reg[0] <= s3_valid_reg;
            for (int k = 1; k <= NDIV; k++)
            begin
                div_valid_reg[k] <= div_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0] <= setup_next;
        end
    end

    for (genvar k = 1; k <= NDIV; k++)
    begin : g_div
        hpt_pkg::div_item_t step_next;
        always_comb
        begin
            step_next = div_reg[k-1];
            for (int c = 0; c < 3; c++)
            begin
                step_next.lanes[c] = div_step(div_reg[k-1].lanes[c], div_reg[k-1].ud);
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[k] <= step_next;
            end
        end
    end

    // Final stage: choose pass-through, zero-w or quotient, then clip.
    hpt_pkg::div_item_t fin;
    logic [hpt_pkg::COORD_W-1:0] res_next [3];
    logic [2:0] lane_sat;
    logic sat_next;

    always_comb
    begin
        fin = div_reg[NDIV];
        for (int c = 0; c < 3; c++)
        begin
            lane_sat[c] = 1'b0;
            if (fin.w_one)
            begin
                if (fin.lanes[c].v > hpt_pkg::ROW_W'(signed'(hpt_pkg::SAT_MAX)))
                begin
                    res_next[c] = hpt_pkg::SAT_MAX;
                    lane_sat[c] = 1'b1;
                end
                else if (fin.lanes[c].v < hpt_pkg::ROW_W'(signed'(hpt_pkg::SAT_MIN)))
                begin
                    res_next[c] = hpt_pkg::SAT_MIN;
                    lane_sat[c] = 1'b1;
                end
                else
                begin
                    res_next[c] = fin.lanes[c].v[hpt_pkg::COORD_W-1:0];
                end
            end
            else if (fin.w_zero)
            begin
                if (fin.lanes[c].v > 0)
                    res_next[c] = hpt_pkg::SAT_MAX;
                else if (fin.lanes[c].v < 0)
                    res_next[c] = hpt_pkg::SAT_MIN;
                else
                    res_next[c] = '0;
            end
            else if (fin.lanes[c].ovf)
            begin
                res_next[c] = fin.lanes[c].neg ? hpt_pkg::SAT_MIN : hpt_pkg::SAT_MAX;
                lane_sat[c] = 1'b1;
            end
            else if (fin.lanes[c].neg)
            begin
                if (fin.lanes[c].quo > hpt_pkg::SAT_MIN)
                begin
                    res_next[c] = hpt_pkg::SAT_MIN;
                    lane_sat[c] = 1'b1;
                end
                else
                begin
                    res_next[c] = -fin.lanes[c].quo;
                end
            end
            else if (fin.lanes[c].quo > hpt_pkg::SAT_MAX)
            begin
                res_next[c] = hpt_pkg::SAT_MAX;
                lane_sat[c] = 1'b1;
            end
            else
            begin
                res_next[c] = fin.lanes[c].quo;
            end
        end
        sat_next = !fin.w_zero && (|lane_sat);
    end

    // Output register.
    logic [hpt_pkg::COORD_W-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic                        wz_reg, sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_valid_reg[NDIV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_x_reg <= res_next[0];
            res_y_reg <= res_next[1];
            res_z_reg <= res_next[2];
            wz_reg    <= fin.w_zero;
            sat_reg   <= sat_next;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.result_x   = signed'(res_x_reg);
    assign res.result_y   = signed'(res_y_reg);
    assign res.result_z   = signed'(res_z_reg);
    assign res.w_was_zero = wz_reg;
    assign res.saturated  = sat_reg;

endmodule

/* rtl/hpt_checker.sv */
// ============================================================================
// Homogeneous point transform checker
// Port-level assertions, attached to the top level by a bind statement.
// ============================================================================
module hpt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [hpt_pkg::COORD_W-1:0] result_x,
    input logic                        w_was_zero,
    input logic                        saturated
);

    // A stalled output stalls the whole pipeline, input included.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input ready while output stalled");

    // A stalled beat stays.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_x))
        else $error("stalled result beat changed");

    // A zero w never reports clipping.
    a_wz_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && w_was_zero |-> !saturated)
        else $error("saturated set with zero w");

    // A zero w gives only the two limits or zero.
    a_wz_values: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && w_was_zero |-> result_x == hpt_pkg::SAT_MAX
            || result_x == hpt_pkg::SAT_MIN || result_x == '0)
        else $error("zero w result out of set");

endmodule

bind homogeneous_point_transform_unit hpt_checker u_hpt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (pt.ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .result_x   (res.result_x),
    .w_was_zero (res.w_was_zero),
    .saturated  (res.saturated)
);
